>>> rtl/core/pbfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfn_pkg: shared types and constants
// Widths and the accumulator record passed from front end to normalizer.
// ----------------------------------------------------------------------------
package pbfn_pkg;

    localparam int COORD_BITS_DEF   = 24;
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int SUM_W            = 64;
    localparam int NRM_W            = 32;
    localparam int ONE_Q30          = 1 << 30;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } t_sum;

endpackage

>>> rtl/core/pbfn_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfn_vtx_if / pbfn_nrm_if: request channels
// Valid/ready channels for vertex requests and normal results.
// ----------------------------------------------------------------------------
interface pbfn_vtx_if #(
    parameter int COORD_BITS = pbfn_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic signed [COORD_BITS-1:0] vertex_z;
    logic                         last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex,
                    output ready);
endinterface

interface pbfn_nrm_if;
    logic                               valid;
    logic                               ready;
    logic signed [pbfn_pkg::NRM_W-1:0]  normal_x;
    logic signed [pbfn_pkg::NRM_W-1:0]  normal_y;
    logic signed [pbfn_pkg::NRM_W-1:0]  normal_z;
    logic                               degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                    output ready);
endinterface

>>> rtl/core/polygon_best_fit_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_best_fit_normal: streaming Newell polygon normal
// Accumulates Newell edge terms per vertex and emits the unit normal.
// ----------------------------------------------------------------------------
// Usage:
//  i_vtx carries one vertex per request (Q12.12 x/y/z plus last_vertex).
//  o_nrm carries one Q1.30 unit normal per polygon, with a degenerate flag
//  set (and zero components) when the Newell sum is zero.
//  For each vertex after the first, the front end does an edge multiply, then a
//  saturating 64-bit add; the first vertex of a polygon is only stored, unless
//  it is also the last. The last vertex adds the closing edge the same way, and
//  the sums are then pushed into a two-entry queue.
//  The normalizer then finds the largest magnitude, shifts it under 2^31,
//  squares and sums the components, takes a bit-serial root and does a
//  bit-serial divide per component. A zero sum goes straight to the output.
//  While it works, the front end keeps taking the next polygon's vertices
//  until the queue holds two pending sums.
//  A receiver that holds ready low stalls the normalizer at its output
//  register; the queue then fills and the vertex side backs up.
//  Synchronous active-low reset empties the queue and drops any partial
//  polygon; the next vertex starts a new one.
// ----------------------------------------------------------------------------
module polygon_best_fit_normal #(
    parameter int COORD_BITS   = pbfn_pkg::COORD_BITS_DEF,
    parameter int MAX_VERTICES = pbfn_pkg::MAX_VERTICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbfn_vtx_if.sink   i_vtx,
    pbfn_nrm_if.source o_nrm
);
    import pbfn_pkg::*;

    // front end -> queue
    logic push_valid;
    logic push_ready;
    t_sum push_sums;

    // queue -> normalizer
    logic pop_valid;
    logic pop_ready;
    t_sum pop_sums;

    pbfn_front #(
        .COORD_BITS   (COORD_BITS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (i_vtx),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_sums  (push_sums)
    );

    pbfn_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (push_valid),
        .o_wr_ready (push_ready),
        .i_wr_data  (push_sums),
        .o_rd_valid (pop_valid),
        .i_rd_ready (pop_ready),
        .o_rd_data  (pop_sums)
    );

    pbfn_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .o_q_ready (pop_ready),
        .i_q_data  (pop_sums),
        .o_nrm     (o_nrm)
    );

endmodule

>>> rtl/core/pbfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfn_front: vertex intake and Newell accumulation
// Takes vertices, adds edge cross terms with 64-bit saturation, hands sums on.
// ----------------------------------------------------------------------------
module pbfn_front #(
    parameter int COORD_BITS   = pbfn_pkg::COORD_BITS_DEF,
    parameter int MAX_VERTICES = pbfn_pkg::MAX_VERTICES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pbfn_vtx_if.sink       i_vtx,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output pbfn_pkg::t_sum o_push_sums
);
    import pbfn_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} t_fstate;

    typedef logic signed [COORD_BITS-1:0] t_crd;

    t_fstate             r_state;
    logic                r_have_first;
    logic [CW-1:0]       r_cnt;
    logic                r_fin;
    logic                r_closing;
    t_crd                r_first [3];
    t_crd                r_prev  [3];
    t_crd                r_ep    [3];
    t_crd                r_ec    [3];
    logic signed [PW-1:0] r_prod [3];
    logic signed [SUM_W-1:0] r_sum [3];

    t_crd                cur [3];
    logic [CW-1:0]       n_cnt;
    logic                last_eff;
    logic signed [EW-1:0] s_a [3];
    logic signed [EW-1:0] d_a [3];
    logic signed [SUM_W-1:0] sat [3];
    logic signed [SUM_W:0]   wide [3];

    assign cur[0] = i_vtx.vertex_x;
    assign cur[1] = i_vtx.vertex_y;
    assign cur[2] = i_vtx.vertex_z;

    assign i_vtx.ready  = (r_state == F_IDLE);
    assign o_push_valid = (r_state == F_PUSH);
    assign o_push_sums  = '{x: r_sum[0], y: r_sum[1], z: r_sum[2]};

    assign n_cnt    = r_have_first ? r_cnt + CW'(1) : CW'(1);
    assign last_eff = i_vtx.last_vertex || (n_cnt == CW'(MAX_VERTICES));

    // x: (pz+cz)(py-cy), y: (px+cx)(pz-cz), z: (py+cy)(px-cx)
    always_comb begin
        s_a[0] = EW'(r_ep[2]) + EW'(r_ec[2]);
        d_a[0] = EW'(r_ep[1]) - EW'(r_ec[1]);
        s_a[1] = EW'(r_ep[0]) + EW'(r_ec[0]);
        d_a[1] = EW'(r_ep[2]) - EW'(r_ec[2]);
        s_a[2] = EW'(r_ep[1]) + EW'(r_ec[1]);
        d_a[2] = EW'(r_ep[0]) - EW'(r_ec[0]);
        for (int i = 0; i < 3; i++) begin
            wide[i] = {r_sum[i][SUM_W-1], r_sum[i]} + (SUM_W+1)'(r_prod[i]);
            if (wide[i][SUM_W] != wide[i][SUM_W-1])
                sat[i] = wide[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
            else
                sat[i] = wide[i][SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_have_first <= 1'b0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_vtx.valid) begin
                        r_cnt <= n_cnt;
                        for (int i = 0; i < 3; i++) r_prev[i] <= cur[i];
                        if (!r_have_first) begin
                            r_have_first <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_first[i] <= cur[i];
                                r_sum[i]   <= '0;
                                r_ep[i]    <= cur[i];
                                r_ec[i]    <= cur[i];
                            end
                            r_fin     <= 1'b1;
                            r_closing <= 1'b1;
                            if (last_eff) r_state <= F_MUL;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_ep[i] <= r_prev[i];
                                r_ec[i] <= cur[i];
                            end
                            r_fin     <= last_eff;
                            r_closing <= 1'b0;
                            r_state   <= F_MUL;
                        end
                    end
                end
                F_MUL: begin
                    for (int i = 0; i < 3; i++) r_prod[i] <= s_a[i] * d_a[i];
                    r_state <= F_ACC;
                end
                F_ACC: begin
                    for (int i = 0; i < 3; i++) r_sum[i] <= sat[i];
                    if (r_fin && !r_closing) begin
                        // closing edge: last vertex back to the first
                        for (int i = 0; i < 3; i++) begin
                            r_ep[i] <= r_prev[i];
                            r_ec[i] <= r_first[i];
                        end
                        r_closing <= 1'b1;
                        r_state   <= F_MUL;
                    end else if (r_fin) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_state <= F_IDLE;
                    end
                end
                F_PUSH: begin
                    if (i_push_ready) begin
                        r_have_first <= 1'b0;
                        r_state      <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/pbfn_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfn_queue: two-entry FIFO
// Decouples accumulation from normalization.
// ----------------------------------------------------------------------------
module pbfn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  pbfn_pkg::t_sum i_wr_data,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output pbfn_pkg::t_sum o_rd_data
);
    import pbfn_pkg::*;

    t_sum       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_mem[r_wp] <= i_wr_data;
                r_wp        <= ~r_wp;
            end
            if (rd_en) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

>>> rtl/core/pbfn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbfn_norm: vector normalizer
// Scales, squares, takes the integer root and divides bit-serially.
// ----------------------------------------------------------------------------
module pbfn_norm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  pbfn_pkg::t_sum i_q_data,
    pbfn_nrm_if.source     o_nrm
);
    import pbfn_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_MAX, B_SHIFT, B_SQM, B_SQA, B_SQRT, B_DIVL, B_DIV, B_OUT
    } t_bstate;

    t_bstate           r_state;
    logic [SUM_W-1:0]  r_m   [3];
    logic              r_neg [3];
    logic [SUM_W-1:0]  r_max;
    logic [SUM_W-1:0]  r_sq;
    logic [61:0]       r_prod;
    logic [1:0]        r_idx;
    logic [5:0]        r_cnt;
    logic [SUM_W-1:0]  r_rad;
    logic [33:0]       r_rem;
    logic [31:0]       r_root;
    logic [61:0]       r_num;
    logic [31:0]       r_drem;
    logic [60:0]       r_quo;
    logic [NRM_W-1:0]  r_nrm [3];
    logic              r_deg;
    logic              r_ovalid;

    logic signed [SUM_W-1:0] sv [3];
    logic [SUM_W-1:0]  mx01;
    logic [SUM_W-1:0]  mx;
    logic [35:0]       rem_n;
    logic [35:0]       trial;
    logic [32:0]       dr_n;
    logic              qbit;
    logic [61:0]       qf;
    logic [NRM_W-1:0]  q32;
    logic [SUM_W-1:0]  sq_n;

    assign sv[0] = i_q_data.x;
    assign sv[1] = i_q_data.y;
    assign sv[2] = i_q_data.z;

    assign o_q_ready        = (r_state == B_IDLE);
    assign o_nrm.valid      = r_ovalid;
    assign o_nrm.normal_x   = r_nrm[0];
    assign o_nrm.normal_y   = r_nrm[1];
    assign o_nrm.normal_z   = r_nrm[2];
    assign o_nrm.degenerate = r_deg;

    always_comb begin
        mx01  = (r_m[0] > r_m[1]) ? r_m[0] : r_m[1];
        mx    = (mx01 > r_m[2]) ? mx01 : r_m[2];
        rem_n = {r_rem, r_rad[SUM_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        dr_n  = {r_drem, r_num[61]};
        qbit  = (dr_n >= {1'b0, r_root});
        qf    = {r_quo, qbit};
        q32   = (qf > 62'(ONE_Q30)) ? NRM_W'(ONE_Q30) : qf[NRM_W-1:0];
        sq_n  = r_sq + SUM_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= sv[i][SUM_W-1];
                            r_m[i]   <= sv[i][SUM_W-1] ? SUM_W'(-sv[i]) : SUM_W'(sv[i]);
                        end
                        r_state <= B_MAX;
                    end
                end
                B_MAX: begin
                    if (mx == '0) begin
                        for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
                        r_deg    <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= B_OUT;
                    end else begin
                        r_max   <= mx;
                        r_state <= B_SHIFT;
                    end
                end
                B_SHIFT: begin
                    // bring the largest magnitude under 2^31
                    if (r_max[SUM_W-1:31] != '0) begin
                        r_max <= r_max >> 1;
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else begin
                        r_sq    <= '0;
                        r_idx   <= 2'd0;
                        r_state <= B_SQM;
                    end
                end
                B_SQM: begin
                    r_prod  <= r_m[r_idx][30:0] * r_m[r_idx][30:0];
                    r_state <= B_SQA;
                end
                B_SQA: begin
                    r_sq <= sq_n;
                    if (r_idx == 2'd2) begin
                        r_rad   <= sq_n;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= B_SQRT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= B_SQM;
                    end
                end
                B_SQRT: begin
                    // one root bit per cycle
                    if (rem_n >= trial) begin
                        r_rem  <= 34'(rem_n - trial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= rem_n[33:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_idx   <= 2'd0;
                        r_state <= B_DIVL;
                    end
                end
                B_DIVL: begin
                    // numerator t*2^30 + len/2 rounds half away from zero
                    r_num   <= {1'b0, r_m[r_idx][30:0], 30'd0} + 62'(r_root[31:1]);
                    r_drem  <= '0;
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_drem <= qbit ? 32'(dr_n - {1'b0, r_root}) : dr_n[31:0];
                    r_num  <= r_num << 1;
                    r_quo  <= qf[60:0];
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == 6'd61) begin
                        r_nrm[r_idx] <= r_neg[r_idx] ? -q32 : q32;
                        if (r_idx == 2'd2) begin
                            r_deg    <= 1'b0;
                            r_ovalid <= 1'b1;
                            r_state  <= B_OUT;
                        end else begin
                            r_idx   <= r_idx + 2'd1;
                            r_state <= B_DIVL;
                        end
                    end
                end
                B_OUT: begin
                    if (o_nrm.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: polygon normal regression
// Streams directed and random polygons into the Newell normal block and
// compares each unit normal with a fixed-point predictor kept alongside.
// ----------------------------------------------------------------------------
module tb_top;
    import pbfn_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int MAXV    = MAX_VERTICES_DEF;
    localparam int N_RAND  = 1850;
    localparam int WD_MAX  = 20000;   // idle cycles allowed
    localparam int TAIL    = 400;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 last;
    } t_vertex;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    degen;
    } t_normal;

    logic i_clk;
    logic i_rst_n;

    pbfn_vtx_if #(.COORD_BITS(CB)) vtx ();
    pbfn_nrm_if                    nrm ();

    polygon_best_fit_normal #(.COORD_BITS(CB), .MAX_VERTICES(MAXV)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx),
        .o_nrm  (nrm)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // vertex requests waiting to be driven, normals waiting to arrive
    t_vertex vtx_pending[$];
    t_normal normals_due[$];

    // predictor state
    logic signed [63:0] first_pt[3];
    logic signed [63:0] prev_pt[3];
    logic signed [63:0] acc[3];
    bit                 holding_first;
    int unsigned        vcnt;

    int  n_fail;
    int  n_polys;
    int  n_degen;
    bit  stim_done;
    bit  long_hold;

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7fff_ffff_ffff_ffff) return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    task automatic add_newell_edge(input logic signed [63:0] p[3],
                                   input logic signed [63:0] c[3]);
        acc[0] = sat_sum(acc[0], (p[2] + c[2]) * (p[1] - c[1]));
        acc[1] = sat_sum(acc[1], (p[0] + c[0]) * (p[2] - c[2]));
        acc[2] = sat_sum(acc[2], (p[1] + c[1]) * (p[0] - c[0]));
    endtask

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector of the current sum, Q1.30, rounded half away from zero
    function automatic t_normal unit_normal();
        t_normal     n;
        logic [63:0] mag[3], t[3], peak, sq, len;
        logic [95:0] q;
        logic signed [NRM_W-1:0] comp[3];
        int          k;
        peak = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = acc[i][63] ? 64'd0 - acc[i] : acc[i];
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) begin
            n = '0;
            n.degen = 1'b1;
            return n;
        end
        k = 0;
        while ((peak >> k) >= (64'h1 << 31)) k++;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            t[i] = mag[i] >> k;
            sq = sq + t[i] * t[i];
        end
        len = int_root(sq);
        for (int i = 0; i < 3; i++) begin
            q = ({32'd0, t[i]} << 30) + (len >> 1);
            q = q / len;
            if (q > ONE_Q30) q = ONE_Q30;
            comp[i] = acc[i][63] ? -q[31:0] : q[31:0];
        end
        n.nx = comp[0];
        n.ny = comp[1];
        n.nz = comp[2];
        n.degen = 1'b0;
        return n;
    endfunction

    task automatic predict_vertex(input t_vertex v);
        logic signed [63:0] cur[3];
        bit closes;
        cur[0] = v.x;
        cur[1] = v.y;
        cur[2] = v.z;
        closes = v.last;
        if (!holding_first) begin
            first_pt = cur;
            acc = '{0, 0, 0};
            holding_first = 1;
            vcnt = 0;
        end else begin
            add_newell_edge(prev_pt, cur);
        end
        prev_pt = cur;
        if (vcnt < MAXV) vcnt++;
        if (vcnt >= MAXV) closes = 1;
        if (closes) begin
            add_newell_edge(cur, first_pt);
            normals_due.push_back(unit_normal());
            acc = '{0, 0, 0};
            holding_first = 0;
            vcnt = 0;
        end
    endtask

    function automatic logic signed [CB-1:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            1: return $signed(10'($urandom)) <<< 8;      // small values
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic queue_polygon(int nverts, int mode, bit planar);
        t_vertex v;
        for (int i = 0; i < nverts; i++) begin
            v.x = rnd_coord(mode);
            v.y = rnd_coord(mode);
            v.z = planar ? (CB)'(0) : rnd_coord(mode);
            v.last = (i == nverts - 1);
            vtx_pending.push_back(v);
        end
    endtask

    // stimulus
    initial begin
        t_vertex v;
        int n;
        n_fail = 0;
        stim_done = 0;
        holding_first = 0;
        vcnt = 0;
        // directed: single vertex, collinear, full-scale corners, planar square, full-scale hexagon
        v = '{x: 100, y: -5, z: 7, last: 1};
        vtx_pending.push_back(v);
        v = '{x: 0, y: 0, z: 0, last: 0};      vtx_pending.push_back(v);
        v = '{x: 1, y: 1, z: 1, last: 0};      vtx_pending.push_back(v);
        v = '{x: 2, y: 2, z: 2, last: 1};      vtx_pending.push_back(v);
        v = '{x: {1'b0, {(CB-1){1'b1}}}, y: {1'b1, {(CB-1){1'b0}}},
              z: {1'b0, {(CB-1){1'b1}}}, last: 0};
        vtx_pending.push_back(v);
        v = '{x: {1'b1, {(CB-1){1'b0}}}, y: {1'b0, {(CB-1){1'b1}}},
              z: {1'b1, {(CB-1){1'b0}}}, last: 0};
        vtx_pending.push_back(v);
        v = '{x: {1'b0, {(CB-1){1'b1}}}, y: {1'b0, {(CB-1){1'b1}}},
              z: {1'b1, {(CB-1){1'b0}}}, last: 1};
        vtx_pending.push_back(v);
        v = '{x: 0, y: 0, z: 0, last: 0};           vtx_pending.push_back(v);
        v = '{x: 4096, y: 0, z: 0, last: 0};        vtx_pending.push_back(v);
        v = '{x: 4096, y: 4096, z: 0, last: 0};     vtx_pending.push_back(v);
        v = '{x: 0, y: 4096, z: 0, last: 1};        vtx_pending.push_back(v);
        queue_polygon(6, 0, 0);
        // random polygons, mostly short; room is left for the overlong run
        // that hits the vertex cap, so the total stays near N_RAND
        n = vtx_pending.size();
        while (n < N_RAND - (MAXV + 5)) begin
            int nv;
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                             : $urandom_range(3, 8);
            queue_polygon(nv, $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 2),
                          $urandom_range(0, 3) == 0);
            n += nv;
        end
        for (int i = 0; i < MAXV + 5; i++) begin
            v.x = rnd_coord(1);
            v.y = rnd_coord(1);
            v.z = rnd_coord(1);
            v.last = (i == MAXV + 4);
            vtx_pending.push_back(v);
        end
        wait (i_rst_n === 1'b1);
        wait (vtx_pending.size() == 0 && !vtx.valid);
        stim_done = 1;
    end

    // reset and drivers' initial values
    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: bursts of requests with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx.valid       <= 1'b0;
            vtx.vertex_x    <= '0;
            vtx.vertex_y    <= '0;
            vtx.vertex_z    <= '0;
            vtx.last_vertex <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end else if (!vtx.valid || vtx.ready) begin
            if (vtx.valid) predict_vertex({vtx.vertex_x, vtx.vertex_y, vtx.vertex_z,
                                           vtx.last_vertex});
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                vtx.valid  <= 1'b0;
            end else if (vtx_pending.size() > 0) begin
                t_vertex nv;
                nv = vtx_pending.pop_front();
                vtx.valid       <= 1'b1;
                vtx.vertex_x    <= nv.x;
                vtx.vertex_y    <= nv.y;
                vtx.vertex_z    <= nv.z;
                vtx.last_vertex <= nv.last;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                vtx.valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus one long hold-off early on
    int hold_cnt;
    int phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nrm.ready <= 1'b0;
            hold_cnt  <= 0;
            phase     <= 0;
            long_hold <= 0;
        end else begin
            phase <= phase + 1;
            if (!long_hold && n_polys == 20) begin
                long_hold <= 1;
                hold_cnt  <= 3000;
                nrm.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt  <= hold_cnt - 1;
                nrm.ready <= 1'b0;
            end else if (phase[10]) begin
                nrm.ready <= 1'b1;          // stretch with no stalls
            end else begin
                nrm.ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // monitor: check each normal against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && nrm.valid && nrm.ready) begin
            t_normal exp_n;
            if (normals_due.size() == 0) begin
                $error("normal with no prediction pending");
                n_fail++;
            end else begin
                exp_n = normals_due.pop_front();
                n_polys++;
                if (exp_n.degen) n_degen++;
                if (nrm.normal_x !== exp_n.nx) begin
                    $error("normal_x exp %0d got %0d", exp_n.nx, nrm.normal_x);
                    n_fail++;
                end
                if (nrm.normal_y !== exp_n.ny) begin
                    $error("normal_y exp %0d got %0d", exp_n.ny, nrm.normal_y);
                    n_fail++;
                end
                if (nrm.normal_z !== exp_n.nz) begin
                    $error("normal_z exp %0d got %0d", exp_n.nz, nrm.normal_z);
                    n_fail++;
                end
                if (nrm.degenerate !== exp_n.degen) begin
                    $error("degenerate exp %0d got %0d", exp_n.degen, nrm.degenerate);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted vertex or normal
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (vtx.valid && vtx.ready) || (nrm.valid && nrm.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_MAX) begin
            $display("watchdog: %0d normals still due", normals_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // end of run
    initial begin
        n_polys = 0;
        n_degen = 0;
        wait (stim_done);
        wait (normals_due.size() == 0);
        repeat (TAIL) @(posedge i_clk);
        if (normals_due.size() != 0) begin
            $error("%0d normals never arrived", normals_due.size());
            n_fail++;
        end
        $display("covered %0d polygons (%0d degenerate), incl. vertex cap and a long",
                 n_polys, n_degen);
        $display("output stall that backed up the vertex side");
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> polygon_best_fit_normal.f
rtl/core/pbfn_pkg.sv
rtl/core/pbfn_if.sv
rtl/core/pbfn_front.sv
rtl/core/pbfn_queue.sv
rtl/core/pbfn_norm.sv
rtl/core/polygon_best_fit_normal.sv
tb/tb_top.sv
